FILE: src/sts_pkg.sv
package sts_pkg;

  // Counter widths of the scanner.
  localparam int POSITION_WIDTH = 16;
  localparam int LINE_WIDTH     = 16;

  // Widths of the result fields.
  localparam int FIELD_W = 16;
  localparam int KIND_W  = 5;
  localparam int ERR_W   = 2;

  // At most three results leave for one input transaction.
  localparam int MAX_RES     = 3;
  localparam int CNT_W       = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POSITION_WIDTH-1:0] pos_t;
  typedef logic [LINE_WIDTH-1:0]     line_t;

  localparam pos_t  POS_MAX  = '1;
  localparam line_t LINE_MAX = '1;
  localparam line_t LINE_ONE = line_t'(1);

  // Token kinds.
  localparam logic [KIND_W-1:0] K_LPAREN      = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAREN      = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACE      = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACE      = 5'd3;
  localparam logic [KIND_W-1:0] K_COMMA       = 5'd4;
  localparam logic [KIND_W-1:0] K_DOT         = 5'd5;
  localparam logic [KIND_W-1:0] K_MINUS       = 5'd6;
  localparam logic [KIND_W-1:0] K_PLUS        = 5'd7;
  localparam logic [KIND_W-1:0] K_SEMI        = 5'd8;
  localparam logic [KIND_W-1:0] K_STAR        = 5'd9;
  localparam logic [KIND_W-1:0] K_STAR_STAR   = 5'd10;
  localparam logic [KIND_W-1:0] K_QUESTION    = 5'd11;
  localparam logic [KIND_W-1:0] K_BANG        = 5'd12;
  localparam logic [KIND_W-1:0] K_BANG_EQ     = 5'd13;
  localparam logic [KIND_W-1:0] K_EQ          = 5'd14;
  localparam logic [KIND_W-1:0] K_EQ_EQ       = 5'd15;
  localparam logic [KIND_W-1:0] K_LT          = 5'd16;
  localparam logic [KIND_W-1:0] K_LT_EQ       = 5'd17;
  localparam logic [KIND_W-1:0] K_GT          = 5'd18;
  localparam logic [KIND_W-1:0] K_GT_EQ       = 5'd19;
  localparam logic [KIND_W-1:0] K_SLASH       = 5'd20;
  localparam logic [KIND_W-1:0] K_SLASH_SLASH = 5'd21;
  localparam logic [KIND_W-1:0] K_STRING      = 5'd22;
  localparam logic [KIND_W-1:0] K_NUMBER      = 5'd23;
  localparam logic [KIND_W-1:0] K_IDENT       = 5'd24;
  localparam logic [KIND_W-1:0] K_NONE        = 5'd0;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 2'd2;

  // Pending operator codes.
  localparam logic [2:0] OP_STAR  = 3'd0;
  localparam logic [2:0] OP_BANG  = 3'd1;
  localparam logic [2:0] OP_EQ    = 3'd2;
  localparam logic [2:0] OP_LT    = 3'd3;
  localparam logic [2:0] OP_GT    = 3'd4;
  localparam logic [2:0] OP_SLASH = 3'd5;

  // Characters.
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_LA       = 8'h61;
  localparam logic [7:0] CH_LZ       = 8'h7A;
  localparam logic [7:0] CH_UA       = 8'h41;
  localparam logic [7:0] CH_UZ       = 8'h5A;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_OP,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_IDENT,
    MODE_STRING,
    MODE_COMMENT,
    MODE_HALTED
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [ERR_W-1:0]   err;
    logic               end_m;
  } result_t;

  // All results caused by one input transaction.
  typedef struct packed {
    logic [CNT_W-1:0]           count;
    result_t [MAX_RES-1:0]      res;
  } bundle_t;

  function automatic pos_t sat_pos(input pos_t a, input pos_t b);
    logic [POSITION_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum >= {1'b0, POS_MAX}) ? POS_MAX : sum[POSITION_WIDTH-1:0];
  endfunction

  function automatic line_t line_inc(input line_t a);
    return (a == LINE_MAX) ? LINE_MAX : line_t'(a + LINE_ONE);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB);
  endfunction

  // {hit, kind} for single-character tokens that start no longer token.
  function automatic logic [KIND_W:0] punct_lookup(input logic [7:0] c);
    logic [KIND_W:0] r;
    unique case (c)
      CH_LPAREN:   r = {1'b1, K_LPAREN};
      CH_RPAREN:   r = {1'b1, K_RPAREN};
      CH_LBRACE:   r = {1'b1, K_LBRACE};
      CH_RBRACE:   r = {1'b1, K_RBRACE};
      CH_COMMA:    r = {1'b1, K_COMMA};
      CH_DOT:      r = {1'b1, K_DOT};
      CH_MINUS:    r = {1'b1, K_MINUS};
      CH_PLUS:     r = {1'b1, K_PLUS};
      CH_SEMI:     r = {1'b1, K_SEMI};
      CH_QUESTION: r = {1'b1, K_QUESTION};
      default:     r = '0;
    endcase
    return r;
  endfunction

  // {hit, code} for characters that may open a two-character operator.
  function automatic logic [3:0] op_lookup(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      CH_STAR:  r = {1'b1, OP_STAR};
      CH_BANG:  r = {1'b1, OP_BANG};
      CH_EQ:    r = {1'b1, OP_EQ};
      CH_LT:    r = {1'b1, OP_LT};
      CH_GT:    r = {1'b1, OP_GT};
      CH_SLASH: r = {1'b1, OP_SLASH};
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [2:0] op);
    logic [KIND_W-1:0] k;
    unique case (op)
      OP_BANG:  k = K_BANG;
      OP_EQ:    k = K_EQ;
      OP_LT:    k = K_LT;
      OP_GT:    k = K_GT;
      OP_SLASH: k = K_SLASH;
      default:  k = K_STAR;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] op);
    logic [7:0] c;
    unique case (op)
      OP_BANG, OP_EQ, OP_LT, OP_GT: c = CH_EQ;
      OP_SLASH:                     c = CH_SLASH;
      default:                      c = CH_STAR;
    endcase
    return c;
  endfunction

  function automatic result_t mk_result(input logic [KIND_W-1:0] kind, input line_t line,
                                        input pos_t start, input pos_t len,
                                        input logic [ERR_W-1:0] err, input logic end_m);
    result_t r;
    r.kind  = kind;
    r.line  = FIELD_W'(line);
    r.start = FIELD_W'(start);
    r.len   = FIELD_W'(len);
    r.err   = err;
    r.end_m = end_m;
    return r;
  endfunction

endpackage

FILE: src/sts_if.sv
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source(output valid, char_byte, end_of_source, input ready);
  modport sink(input valid, char_byte, end_of_source, output ready);
endinterface

interface sts_out_if import sts_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [FIELD_W-1:0] line_number;
  logic [FIELD_W-1:0] start_pos;
  logic [FIELD_W-1:0] token_length;
  logic [ERR_W-1:0]   error_code;
  logic               end_marker;
  logic               last_in_run;

  modport source(output valid, token_kind, line_number, start_pos, token_length, error_code,
                 end_marker, last_in_run, input ready);
  modport sink(input valid, token_kind, line_number, start_pos, token_length, error_code,
               end_marker, last_in_run, output ready);
endinterface

FILE: src/sts_front.sv
module sts_front import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sts_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_data
);

  mode_t      mode_r, mode_nxt;
  logic [2:0] pend_r, pend_nxt;
  line_t      line_r, line_nxt;
  pos_t       pos_r, pos_nxt;
  pos_t       tstart_r, tstart_nxt;
  pos_t       tlen_r, tlen_nxt;

  logic            accept;
  logic [7:0]      c;
  logic            eos;
  logic [KIND_W:0] punct;
  logic [3:0]      opl;
  logic            dig;
  logic            alnum;
  logic            unexpected;
  logic            do_idle;
  bundle_t         bundle_c;
  logic [CNT_W-1:0] cnt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_byte;
  assign eos         = in_ch.end_of_source;

  assign punct      = punct_lookup(c);
  assign opl        = op_lookup(c);
  assign dig        = digit_char(c);
  assign alnum      = dig || letter_char(c);
  assign unexpected = !punct[KIND_W] && !opl[3] && (c != CH_HASH) && (c != CH_QUOTE) &&
                      !is_space(c) && (c != CH_NL) && !alnum;

  // The current mode hands the byte on to the idle scan.
  always_comb begin
    unique case (mode_r)
      MODE_HALTED:  do_idle = 1'b0;
      MODE_OP:      do_idle = (c != op_second(pend_r));
      MODE_INT:     do_idle = !dig && (c != CH_DOT);
      MODE_DOT:     do_idle = !dig;
      MODE_FRAC:    do_idle = !dig;
      MODE_IDENT:   do_idle = !alnum;
      MODE_STRING:  do_idle = 1'b0;
      MODE_COMMENT: do_idle = (c == CH_NL);
      default:      do_idle = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    line_nxt   = line_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    pos_nxt    = sat_pos(pos_r, pos_t'(1));
    if (eos) begin
      mode_nxt   = MODE_IDLE;
      pend_nxt   = OP_STAR;
      line_nxt   = LINE_ONE;
      pos_nxt    = '0;
      tstart_nxt = '0;
      tlen_nxt   = '0;
    end else begin
      unique case (mode_r)
        MODE_HALTED: ;
        MODE_OP:     mode_nxt = MODE_IDLE;
        MODE_INT: begin
          if (dig) begin
            tlen_nxt = sat_pos(tlen_r, pos_t'(1));
          end else if (c == CH_DOT) begin
            mode_nxt = MODE_DOT;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_DOT: begin
          if (dig) begin
            tlen_nxt = sat_pos(tlen_r, pos_t'(2));
            mode_nxt = MODE_FRAC;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_FRAC, MODE_IDENT: begin
          if (!do_idle) begin
            tlen_nxt = sat_pos(tlen_r, pos_t'(1));
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
          end else begin
            tlen_nxt = sat_pos(tlen_r, pos_t'(1));
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            mode_nxt = MODE_IDLE;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase
      if (do_idle) begin
        priority if (punct[KIND_W]) begin
        end else if (opl[3]) begin
          mode_nxt   = MODE_OP;
          pend_nxt   = opl[2:0];
          tstart_nxt = pos_r;
          tlen_nxt   = pos_t'(1);
        end else if (c == CH_HASH) begin
          mode_nxt = MODE_COMMENT;
        end else if (c == CH_QUOTE) begin
          mode_nxt   = MODE_STRING;
          tstart_nxt = sat_pos(pos_r, pos_t'(1));
          tlen_nxt   = '0;
        end else if (is_space(c)) begin
        end else if (c == CH_NL) begin
          line_nxt = line_inc(line_r);
        end else if (dig) begin
          mode_nxt   = MODE_INT;
          tstart_nxt = pos_r;
          tlen_nxt   = pos_t'(1);
        end else if (alnum) begin
          mode_nxt   = MODE_IDENT;
          tstart_nxt = pos_r;
          tlen_nxt   = pos_t'(1);
        end else begin
          mode_nxt = MODE_HALTED;
        end
      end
    end
  end

  // Results of this transaction, in order.
  always_comb begin
    bundle_c = '0;
    cnt      = '0;
    if (eos) begin
      unique case (mode_r)
        MODE_OP: begin
          bundle_c.res[cnt] = mk_result(op_kind(pend_r), line_r, tstart_r, pos_t'(1),
                                        ERR_NONE, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
        end
        MODE_INT, MODE_FRAC: begin
          bundle_c.res[cnt] = mk_result(K_NUMBER, line_r, tstart_r, tlen_r, ERR_NONE, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
        end
        MODE_DOT: begin
          bundle_c.res[cnt] = mk_result(K_NUMBER, line_r, tstart_r, tlen_r, ERR_NONE, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
          bundle_c.res[cnt] = mk_result(K_DOT, line_r, sat_pos(tstart_r, tlen_r), pos_t'(1),
                                        ERR_NONE, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
        end
        MODE_IDENT: begin
          bundle_c.res[cnt] = mk_result(K_IDENT, line_r, tstart_r, tlen_r, ERR_NONE, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
        end
        MODE_STRING: begin
          bundle_c.res[cnt] = mk_result(K_NONE, line_r, tstart_r, tlen_r,
                                        ERR_UNTERMINATED, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
        end
        default: ;
      endcase
      bundle_c.res[cnt] = mk_result(K_NONE, line_r, pos_r, '0, ERR_NONE, 1'b1);
      cnt = CNT_W'(cnt + 1'b1);
    end else begin
      unique case (mode_r)
        MODE_OP: begin
          if (do_idle) begin
            bundle_c.res[cnt] = mk_result(op_kind(pend_r), line_r, tstart_r, pos_t'(1),
                                          ERR_NONE, 1'b0);
          end else begin
            bundle_c.res[cnt] = mk_result(KIND_W'(op_kind(pend_r) + 1'b1), line_r, tstart_r,
                                          pos_t'(2), ERR_NONE, 1'b0);
          end
          cnt = CNT_W'(cnt + 1'b1);
        end
        MODE_INT, MODE_FRAC: begin
          if (do_idle) begin
            bundle_c.res[cnt] = mk_result(K_NUMBER, line_r, tstart_r, tlen_r, ERR_NONE, 1'b0);
            cnt = CNT_W'(cnt + 1'b1);
          end
        end
        MODE_DOT: begin
          if (do_idle) begin
            bundle_c.res[cnt] = mk_result(K_NUMBER, line_r, tstart_r, tlen_r, ERR_NONE, 1'b0);
            cnt = CNT_W'(cnt + 1'b1);
            bundle_c.res[cnt] = mk_result(K_DOT, line_r, sat_pos(tstart_r, tlen_r),
                                          pos_t'(1), ERR_NONE, 1'b0);
            cnt = CNT_W'(cnt + 1'b1);
          end
        end
        MODE_IDENT: begin
          if (do_idle) begin
            bundle_c.res[cnt] = mk_result(K_IDENT, line_r, tstart_r, tlen_r, ERR_NONE, 1'b0);
            cnt = CNT_W'(cnt + 1'b1);
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            bundle_c.res[cnt] = mk_result(K_STRING, line_r, tstart_r, tlen_r, ERR_NONE, 1'b0);
            cnt = CNT_W'(cnt + 1'b1);
          end
        end
        default: ;
      endcase
      if (do_idle) begin
        if (punct[KIND_W]) begin
          bundle_c.res[cnt] = mk_result(punct[KIND_W-1:0], line_r, pos_r, pos_t'(1),
                                        ERR_NONE, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
        end else if (unexpected) begin
          bundle_c.res[cnt] = mk_result(K_NONE, line_r, pos_r, pos_t'(1),
                                        ERR_UNEXPECTED, 1'b0);
          cnt = CNT_W'(cnt + 1'b1);
        end
      end
    end
    bundle_c.count = cnt;
  end

  assign push      = accept && (bundle_c.count != '0);
  assign push_data = bundle_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pend_r   <= OP_STAR;
      line_r   <= LINE_ONE;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
    end
  end

endmodule

FILE: src/sts_queue.sv
module sts_queue import sts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    head_valid,
  output logic    full
);

  bundle_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= QCNT_W'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= QCNT_W'(count_r - 1'b1);
      end
    end
  end

endmodule

FILE: src/sts_back.sv
module sts_back import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    head,
  input  logic       head_valid,
  output logic       pop,
  sts_out_if.source  out_ch
);

  logic             out_valid_r;
  result_t          out_res_r;
  logic             out_last_r;
  logic [CNT_W-1:0] idx_r;

  logic load;
  logic take;
  logic last;

  assign load = !out_valid_r || out_ch.ready;
  assign take = load && head_valid;
  assign last = (idx_r == CNT_W'(head.count - 1'b1));
  assign pop  = take && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (take) begin
        idx_r <= last ? '0 : CNT_W'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r  <= head.res[idx_r];
      out_last_r <= last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_kind   = out_res_r.kind;
  assign out_ch.line_number  = out_res_r.line;
  assign out_ch.start_pos    = out_res_r.start;
  assign out_ch.token_length = out_res_r.len;
  assign out_ch.error_code   = out_res_r.err;
  assign out_ch.end_marker   = out_res_r.end_m;
  assign out_ch.last_in_run  = out_last_r;

endmodule

FILE: src/source_token_scanner.sv
// Channel   Dir  Payload                                              Transaction
// in_ch     in   char_byte, end_of_source                             valid && ready
// out_ch    out  token_kind, line_number, start_pos, token_length,    valid && ready
//                error_code, end_marker, last_in_run
//
// One byte is taken per cycle while the queue has room; its results (up to three)
// reach out_ch via the queue and the single output register, one per ready cycle.
// in_ch.ready drops only while the four-entry result queue is full.
// Reset is synchronous (rst_n low) and leaves the scanner idle at line 1, byte 0.
// A stall on out_ch holds the output register and fills the queue; input stalls
// leave the scanner state untouched.
module source_token_scanner import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_ch,
  sts_out_if.source out_ch
);

  logic    push;
  bundle_t push_data;
  logic    pop;
  bundle_t head;
  logic    head_valid;
  logic    q_full;

  // Front: scan each byte, keep the token state and gather its results.
  sts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: hold result groups between the two sides.
  sts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // Back: advance through each group one result per transaction.
  sts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
